[rtl/cau_pkg.sv]
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    // signed product and sum-of-products widths
    localparam int PW     = 2 * DATA_WIDTH;
    localparam int SUMW   = PW + 1;
    // quotient bits kept; the top one flags overflow
    localparam int QB     = DATA_WIDTH + 1;
    localparam int QW     = QB + 1;
    // divider datapath width: holds the divisor shifted up by QB
    localparam int CW     = 3 * DATA_WIDTH + 1;
    localparam int NCELL  = QW;

    localparam int IN_RAW  = CMD_W + 4 * DATA_WIDTH;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 2 * DATA_WIDTH + STAT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEG = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
    localparam logic [STAT_W-1:0] ST_DZ  = 2'd2;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [DATA_WIDTH:0]   sum_t;
    typedef logic signed [PW-1:0]         prod_t;
    typedef logic signed [SUMW-1:0]       wsum_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  sat;
    } sat_t;

    // one divider cell's word: quotient work plus the carried non-divide result
    typedef struct packed {
        logic                  vld;
        logic [CMD_W-1:0]      cmd;
        logic                  dz;
        logic                  neg_re;
        logic                  neg_im;
        logic [CW-1:0]         rem_re;
        logic [CW-1:0]         rem_im;
        logic [CW-1:0]         dsh;
        logic [QW-1:0]         q_re;
        logic [QW-1:0]         q_im;
        logic [DATA_WIDTH-1:0] pre_re;
        logic [DATA_WIDTH-1:0] pre_im;
        logic                  pre_sat;
    } cell_t;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [DATA_WIDTH-1:0] res_im;
        logic [DATA_WIDTH-1:0] res_re;
    } out_t;

    // sign and magnitude to a saturated two's complement word
    function automatic sat_t settle(input logic neg, input logic [CW-1:0] mag);
        logic [CW-1:0] half;
        logic [CW-1:0] nmag;
        sat_t          r;
        half = {{(CW-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
        nmag = -mag;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > half) begin
                r.val = half[DATA_WIDTH-1:0];
                r.sat = 1'b1;
            end else begin
                r.val = nmag[DATA_WIDTH-1:0];
            end
        end else begin
            if (mag > half - 1'b1) begin
                r.val = half[DATA_WIDTH-1:0] - 1'b1;
                r.sat = 1'b1;
            end else begin
                r.val = mag[DATA_WIDTH-1:0];
            end
        end
        return r;
    endfunction

    // saturate a one-bit-wider signed sum
    function automatic sat_t settle_sum(input sum_t s);
        logic [DATA_WIDTH:0] mag;
        mag = s[DATA_WIDTH] ? -s : s;
        return settle(s[DATA_WIDTH], CW'(mag));
    endfunction

endpackage

[rtl/cau_div_cell.sv]
module cau_div_cell
    import cau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  cell_t din,
    output cell_t dout
);

    cell_t dout_reg;
    cell_t dout_next;
    logic  ge_re;
    logic  ge_im;

    // resolve one quotient bit for both parts
    always_comb
    begin
        dout_next = din;
        ge_re     = din.rem_re >= din.dsh;
        ge_im     = din.rem_im >= din.dsh;
        if (ge_re)
        begin
            dout_next.rem_re = din.rem_re - din.dsh;
        end
        if (ge_im)
        begin
            dout_next.rem_im = din.rem_im - din.dsh;
        end
        dout_next.q_re = {din.q_re[QW-2:0], ge_re};
        dout_next.q_im = {din.q_im[QW-2:0], ge_im};
        dout_next.dsh  = din.dsh >> 1;
    end

    // clear the cell word under reset, advance it when enabled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[rtl/complex_arith_unit.sv]
// Complex arithmetic unit: add, subtract, multiply, divide or negate two
// signed Q15.16 complex operands and return a saturated complex result with a
// status (ok, saturated, divide by zero). One word is accepted every cycle
// while the skid stage is empty, and each result passes through four front
// stages (input, products, sums, magnitudes), a row of DATA_WIDTH + 2 divider
// cells that each resolve one quotient bit, and the output register. All
// operations flow through the same row, so results leave in order. A skid
// stage at the output lets the input keep taking words while a result waits.
module complex_arith_unit
    import cau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd, a_re, a_im, b_re, b_im, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // res_re, res_im, status, zero pad
);

    logic en;

    // stage 0: input
    logic             s0_vld_reg;
    logic [CMD_W-1:0] s0_cmd_reg;
    data_t            s0_a_re_reg, s0_a_im_reg, s0_b_re_reg, s0_b_im_reg;

    // stage 1: products and simple results
    logic             s1_vld_reg;
    logic [CMD_W-1:0] s1_cmd_reg;
    prod_t            s1_rr_reg, s1_ii_reg, s1_ir_reg, s1_ri_reg, s1_bb_reg, s1_cc_reg;
    sat_t             s1_pre_re_reg, s1_pre_re_next;
    sat_t             s1_pre_im_reg, s1_pre_im_next;

    // stage 2: sums of products
    logic             s2_vld_reg;
    logic [CMD_W-1:0] s2_cmd_reg;
    wsum_t            s2_num_re_reg, s2_num_re_next;
    wsum_t            s2_num_im_reg, s2_num_im_next;
    logic [PW-1:0]    s2_den_reg;
    sat_t             s2_pre_re_reg, s2_pre_im_reg;

    // stage 3 feeds the divider row
    cell_t            s3_reg, s3_next;
    logic [SUMW-1:0]  mag_re, mag_im;
    sat_t             mul_re, mul_im;

    cell_t            chain [NCELL+1];
    cell_t            last;
    out_t             fin;
    sat_t             div_re, div_im;

    logic             out_vld_reg, skid_vld_reg;
    out_t             out_reg, skid_reg;
    logic             take;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign take     = out_vld_reg && m_tready;

    // stage 1 simple results
    always_comb
    begin
        s1_pre_re_next = '0;
        s1_pre_im_next = '0;
        unique case (s0_cmd_reg)
            CMD_ADD:
            begin
                s1_pre_re_next = settle_sum(sum_t'(s0_a_re_reg) + sum_t'(s0_b_re_reg));
                s1_pre_im_next = settle_sum(sum_t'(s0_a_im_reg) + sum_t'(s0_b_im_reg));
            end
            CMD_SUB:
            begin
                s1_pre_re_next = settle_sum(sum_t'(s0_a_re_reg) - sum_t'(s0_b_re_reg));
                s1_pre_im_next = settle_sum(sum_t'(s0_a_im_reg) - sum_t'(s0_b_im_reg));
            end
            CMD_NEG:
            begin
                s1_pre_re_next = settle_sum(-sum_t'(s0_a_re_reg));
                s1_pre_im_next = settle_sum(-sum_t'(s0_a_im_reg));
            end
            default:
            begin
                s1_pre_re_next = '0;
                s1_pre_im_next = '0;
            end
        endcase
    end

    // stage 2 sums: multiply or conjugate multiply
    always_comb
    begin
        if (s1_cmd_reg == CMD_DIV)
        begin
            s2_num_re_next = wsum_t'(s1_rr_reg) + wsum_t'(s1_ii_reg);
            s2_num_im_next = wsum_t'(s1_ir_reg) - wsum_t'(s1_ri_reg);
        end
        else
        begin
            s2_num_re_next = wsum_t'(s1_rr_reg) - wsum_t'(s1_ii_reg);
            s2_num_im_next = wsum_t'(s1_ir_reg) + wsum_t'(s1_ri_reg);
        end
    end

    // stage 3: magnitudes, product rounding, dividend setup
    always_comb
    begin
        mag_re = s2_num_re_reg[SUMW-1] ? -s2_num_re_reg : s2_num_re_reg;
        mag_im = s2_num_im_reg[SUMW-1] ? -s2_num_im_reg : s2_num_im_reg;
        mul_re = settle(s2_num_re_reg[SUMW-1],
                        (CW'(mag_re) + (CW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        mul_im = settle(s2_num_im_reg[SUMW-1],
                        (CW'(mag_im) + (CW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        s3_next.vld    = s2_vld_reg;
        s3_next.cmd    = s2_cmd_reg;
        s3_next.dz     = s2_den_reg == '0;
        s3_next.neg_re = s2_num_re_reg[SUMW-1];
        s3_next.neg_im = s2_num_im_reg[SUMW-1];
        s3_next.rem_re = (CW'(mag_re) << FRAC_BITS) + CW'(s2_den_reg >> 1);
        s3_next.rem_im = (CW'(mag_im) << FRAC_BITS) + CW'(s2_den_reg >> 1);
        s3_next.dsh    = CW'(s2_den_reg) << QB;
        s3_next.q_re   = '0;
        s3_next.q_im   = '0;
        if (s2_cmd_reg == CMD_MUL)
        begin
            s3_next.pre_re  = mul_re.val;
            s3_next.pre_im  = mul_im.val;
            s3_next.pre_sat = mul_re.sat | mul_im.sat;
        end
        else
        begin
            s3_next.pre_re  = s2_pre_re_reg.val;
            s3_next.pre_im  = s2_pre_im_reg.val;
            s3_next.pre_sat = s2_pre_re_reg.sat | s2_pre_im_reg.sat;
        end
    end

    // hold front valids under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg   <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg   <= s_tvalid;
            s1_vld_reg   <= s0_vld_reg;
            s2_vld_reg   <= s1_vld_reg;
        end
    end

    // advance front payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_cmd_reg     <= s_tdata[CMD_W-1:0];
            s0_a_re_reg    <= s_tdata[CMD_W +: DATA_WIDTH];
            s0_a_im_reg    <= s_tdata[CMD_W + DATA_WIDTH +: DATA_WIDTH];
            s0_b_re_reg    <= s_tdata[CMD_W + 2*DATA_WIDTH +: DATA_WIDTH];
            s0_b_im_reg    <= s_tdata[CMD_W + 3*DATA_WIDTH +: DATA_WIDTH];

            s1_cmd_reg     <= s0_cmd_reg;
            s1_rr_reg      <= prod_t'(s0_a_re_reg) * prod_t'(s0_b_re_reg);
            s1_ii_reg      <= prod_t'(s0_a_im_reg) * prod_t'(s0_b_im_reg);
            s1_ir_reg      <= prod_t'(s0_a_im_reg) * prod_t'(s0_b_re_reg);
            s1_ri_reg      <= prod_t'(s0_a_re_reg) * prod_t'(s0_b_im_reg);
            s1_bb_reg      <= prod_t'(s0_b_re_reg) * prod_t'(s0_b_re_reg);
            s1_cc_reg      <= prod_t'(s0_b_im_reg) * prod_t'(s0_b_im_reg);
            s1_pre_re_reg  <= s1_pre_re_next;
            s1_pre_im_reg  <= s1_pre_im_next;

            s2_cmd_reg     <= s1_cmd_reg;
            s2_num_re_reg  <= s2_num_re_next;
            s2_num_im_reg  <= s2_num_im_next;
            s2_den_reg     <= s1_bb_reg[PW-1:0] + s1_cc_reg[PW-1:0];
            s2_pre_re_reg  <= s1_pre_re_reg;
            s2_pre_im_reg  <= s1_pre_im_reg;
        end
    end

    // advance the divider feed word, clear it under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    // divider row, one quotient bit per cell
    assign chain[0] = s3_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        cau_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    assign last = chain[NCELL];

    // final result select and status
    always_comb
    begin
        div_re = settle(last.neg_re, CW'(last.q_re));
        div_im = settle(last.neg_im, CW'(last.q_im));
        if (last.cmd == CMD_DIV)
        begin
            if (last.dz)
            begin
                fin.res_re = '0;
                fin.res_im = '0;
                fin.status = ST_DZ;
            end
            else
            begin
                fin.res_re = div_re.val;
                fin.res_im = div_im.val;
                fin.status = (div_re.sat | div_im.sat) ? ST_SAT : ST_OK;
            end
        end
        else
        begin
            fin.res_re = last.pre_re;
            fin.res_im = last.pre_im;
            fin.status = last.pre_sat ? ST_SAT : ST_OK;
        end
    end

    // output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (last.vld)
        begin
            if (out_vld_reg && !m_tready)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (last.vld)
        begin
            if (out_vld_reg && !m_tready)
            begin
                skid_reg <= fin;
            end
            else
            begin
                out_reg <= fin;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_W-OUT_RAW){1'b0}}, out_reg};

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a word while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready))
        else $error("skid filled without an output stall");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.status == ST_DZ) |->
            (out_reg.res_re == '0 && out_reg.res_im == '0))
        else $error("divide by zero gave a nonzero result");
`endif

endmodule

[verif/cau_checker.sv]
module cau_checker
    import cau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [DATA_WIDTH-1:0] res_im;
        logic [DATA_WIDTH-1:0] res_re;
    } cresult_t;

    typedef logic signed [255:0] big_t;

    cresult_t expected_q[$];
    logic     sat_flag;

    // clamp an exact signed value into a data word, noting saturation
    function automatic logic [DATA_WIDTH-1:0] clamp_word(input big_t v);
        big_t hi_lim;
        big_t lo_lim;
        hi_lim = (big_t'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo_lim = -(big_t'(1) <<< (DATA_WIDTH - 1));
        if (v > hi_lim) begin
            sat_flag = 1'b1;
            return hi_lim[DATA_WIDTH-1:0];
        end
        if (v < lo_lim) begin
            sat_flag = 1'b1;
            return lo_lim[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    // round magnitude of num/den to nearest, ties away from zero
    function automatic big_t round_quot(input big_t num, input big_t den);
        big_t mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + (den >>> 1)) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic cresult_t predict_complex(input logic [IN_W-1:0] word);
        logic [CMD_W-1:0] op;
        big_t ar, ai, br, bi, den, one;
        cresult_t r;
        op = word[CMD_W-1:0];
        ar = big_t'(signed'(word[CMD_W +: DATA_WIDTH]));
        ai = big_t'(signed'(word[CMD_W + DATA_WIDTH +: DATA_WIDTH]));
        br = big_t'(signed'(word[CMD_W + 2*DATA_WIDTH +: DATA_WIDTH]));
        bi = big_t'(signed'(word[CMD_W + 3*DATA_WIDTH +: DATA_WIDTH]));
        one = big_t'(1) <<< FRAC_BITS;
        r = '0;
        sat_flag = 1'b0;
        case (op)
            CMD_ADD:
            begin
                r.res_re = clamp_word(ar + br);
                r.res_im = clamp_word(ai + bi);
            end
            CMD_SUB:
            begin
                r.res_re = clamp_word(ar - br);
                r.res_im = clamp_word(ai - bi);
            end
            CMD_MUL:
            begin
                r.res_re = clamp_word(round_quot(ar*br - ai*bi, one));
                r.res_im = clamp_word(round_quot(ai*br + ar*bi, one));
            end
            CMD_DIV:
            begin
                den = br*br + bi*bi;
                if (den == 0)
                    r.status = ST_DZ;
                else
                begin
                    r.res_re = clamp_word(round_quot((ar*br + ai*bi) * one, den));
                    r.res_im = clamp_word(round_quot((ai*br - ar*bi) * one, den));
                end
            end
            CMD_NEG:
            begin
                r.res_re = clamp_word(-ar);
                r.res_im = clamp_word(-ai);
            end
            default:
            begin
            end
        endcase
        if (sat_flag && r.status == ST_OK)
            r.status = ST_SAT;
        return r;
    endfunction

    assign pending = expected_q.size();

    // predict on input words, compare on output words
    always @(posedge clk or negedge rst_n)
    begin
        cresult_t got;
        cresult_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_complex(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = cresult_t'(m_tdata[OUT_RAW-1:0]);
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.res_re !== want.res_re || got.res_im !== want.res_im
                        || got.status !== want.status)
                    begin
                        $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                            $time, want.res_re, want.res_im, want.status,
                            got.res_re, got.res_im, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/tb_complex_arith_unit.sv]
module tb_complex_arith_unit;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1830;
    localparam int LATENCY      = DATA_WIDTH + 7;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;
    logic             hold_sink;
    logic             sending_done;

    complex_arith_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cau_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // short gaps mostly, a long one now and then
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // operand part biased toward edge values
    function automatic logic [DATA_WIDTH-1:0] pick_part();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
            2: return '0;
            3: return DATA_WIDTH'(1) << FRAC_BITS;
            4: return DATA_WIDTH'($urandom_range(0, 8)) - 4;
            5: return DATA_WIDTH'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return DATA_WIDTH'($urandom());
        endcase
    endfunction

    function automatic logic [IN_W-1:0] make_word(input logic [CMD_W-1:0] op,
        input logic [DATA_WIDTH-1:0] ar, input logic [DATA_WIDTH-1:0] ai,
        input logic [DATA_WIDTH-1:0] br, input logic [DATA_WIDTH-1:0] bi);
        return IN_W'({bi, br, ai, ar, op});
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(input logic [IN_W-1:0] word);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_gapped(input logic [IN_W-1:0] word);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        send_word(word);
    endtask

    // sink: random stalls, plus one long hold-off while the source keeps going
    initial
    begin
        int g;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (150) @(posedge clk);
                m_tready <= 1'b1;
                wait (!hold_sink);
            end
            else
            begin
                g = sending_done ? 0 : gap_len();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [DATA_WIDTH-1:0] mn;
        logic [DATA_WIDTH-1:0] mx;
        logic [DATA_WIDTH-1:0] one;
        logic [CMD_W-1:0] op;
        int waited;
        mn  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        mx  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        one = DATA_WIDTH'(1) << FRAC_BITS;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        hold_sink    = 1'b0;
        sending_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edges, every op, saturation, divide by zero, unused codes
        send_word(make_word(CMD_ADD, mx, mn, mx, mn));
        send_word(make_word(CMD_ADD, one, '0, one, '0));
        send_word(make_word(CMD_SUB, mn, mx, mx, mn));
        send_word(make_word(CMD_SUB, '0, '0, '0, '0));
        send_word(make_word(CMD_MUL, mx, mx, mx, mn));
        send_word(make_word(CMD_MUL, mn, mn, mn, mn));
        send_word(make_word(CMD_MUL, one, one, one, '0));
        send_word(make_word(CMD_MUL, 32'h0000_8000, '0, 32'h0000_0001, '0));
        send_word(make_word(CMD_MUL, 32'hFFFF_8000, '0, 32'h0000_0001, '0));
        send_word(make_word(CMD_DIV, one, one, '0, '0));
        send_word(make_word(CMD_DIV, mx, mn, 32'h0000_0001, '0));
        send_word(make_word(CMD_DIV, mn, mn, mn, mn));
        send_word(make_word(CMD_DIV, one, '0, 32'd3 << FRAC_BITS, '0));
        send_word(make_word(CMD_DIV, mx, mx, mx, mx));
        send_word(make_word(CMD_DIV, 32'hFFFF_FFFF, '0, mx, mn));
        send_word(make_word(CMD_NEG, mn, mx, mx, mx));
        send_word(make_word(CMD_NEG, '0, one, '0, '0));
        send_word(make_word(3'd5, mx, mx, mx, mx));
        send_word(make_word(3'd6, one, one, one, one));
        send_word(make_word(3'd7, mn, mn, mn, mn));

        // drain before the random part
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 400)
                hold_sink <= 1'b1;
            if (n == 700)
                hold_sink <= 1'b0;
            if (n == 1000)
            begin
                s_tvalid <= 1'b0;
                wait (pending == 0);
                @(posedge clk);
            end
            op = ($urandom_range(0, 19) == 0) ? CMD_W'($urandom_range(5, 7))
                                               : CMD_W'($urandom_range(0, 4));
            if (n >= 1200 && n < 1400)
                send_word(make_word(op, pick_part(), pick_part(), pick_part(), pick_part()));
            else
                send_gapped(make_word(op, pick_part(), pick_part(), pick_part(), pick_part()));
        end
        s_tvalid <= 1'b0;
        sending_done <= 1'b1;

        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

[sim.f]
rtl/cau_pkg.sv
rtl/cau_div_cell.sv
rtl/complex_arith_unit.sv
verif/cau_checker.sv
verif/tb_complex_arith_unit.sv
